@@ hdl/cfsd_pkg.sv @@
// ----------------------------------------------------------------------------
// cfsd_pkg
// Shared types and constants of the CAN frame signal decoder: operation codes,
// the command that travels from the front end to the scanner, the spec table
// entry, the job handed to the arithmetic unit and the state encodings.
// ----------------------------------------------------------------------------
package cfsd_pkg;

    // Depth of the signal spec table and the widths that follow from it.
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;

    // Bus widths: payload fields padded to whole bytes.
    localparam int S_TDATA_W = 208;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 104;

    // Operation codes carried in tuser of the input word.
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_DECODE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        CMD_APPEND,
        CMD_DECODE,
        CMD_CLEAR
    } cmd_kind_t;

    // A classified command waiting in the queue.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] frame_id;
        logic [63:0] frame_data;
        logic [31:0] stamp;
        logic [2:0]  start_byte;
        logic [3:0]  byte_count;
        logic        is_signed;
        logic        big_endian;
        logic [31:0] scale_q16;
        logic [47:0] offset_q16;
    } cmd_t;

    // One entry of the spec table.
    typedef struct packed {
        logic [15:0] frame_id;
        logic [2:0]  start_byte;
        logic [3:0]  byte_count;
        logic        is_signed;
        logic        big_endian;
        logic [31:0] scale_q16;
        logic [47:0] offset_q16;
    } spec_t;

    // Work for the arithmetic unit: a value to scale, or the end of a frame.
    typedef struct packed {
        logic             is_end;
        logic [IDX_W-1:0] spec_index;
        logic [31:0]      stamp;
        logic [64:0]      raw;
        logic [31:0]      scale_q16;
        logic [47:0]      offset_q16;
    } job_t;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_CHECK,
        SCAN_END
    } scan_state_t;

    typedef enum logic [2:0] {
        AR_IDLE,
        AR_MUL_LO,
        AR_MUL_HI,
        AR_SUM,
        AR_PLACE,
        AR_FLUSH
    } arith_state_t;

endpackage

@@ hdl/cfsd_front.sv @@
// ----------------------------------------------------------------------------
// cfsd_front
// Accepts input words, classifies the operation, clamps the byte count and
// holds the commands in a two-entry queue for the scanner.
// ----------------------------------------------------------------------------
module cfsd_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cfsd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [cfsd_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            head_valid,
    output cfsd_pkg::cmd_t                  head,
    input  logic                            pop
);

    cfsd_pkg::cmd_t q_reg [2];
    logic [1:0]     fill_reg, fill_next;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;

    cfsd_pkg::cmd_t cls;
    logic           cls_keep;
    logic           push;
    logic [3:0]     bytes_left;
    logic [3:0]     cnt_in;

    always_comb
    begin
        cnt_in     = s_tdata[118:115];
        bytes_left = 4'd8 - {1'b0, s_tdata[114:112]};

        cls.frame_id   = s_tdata[15:0];
        cls.frame_data = s_tdata[79:16];
        cls.stamp      = s_tdata[111:80];
        cls.start_byte = s_tdata[114:112];
        cls.byte_count = (cnt_in > bytes_left) ? bytes_left : cnt_in;
        cls.is_signed  = s_tdata[119];
        cls.big_endian = s_tdata[120];
        cls.scale_q16  = s_tdata[152:121];
        cls.offset_q16 = s_tdata[200:153];
        cls.kind       = cfsd_pkg::CMD_APPEND;
        cls_keep       = 1'b1;

        unique case (s_tuser)
            cfsd_pkg::OP_APPEND: cls.kind = cfsd_pkg::CMD_APPEND;
            cfsd_pkg::OP_DECODE: cls.kind = cfsd_pkg::CMD_DECODE;
            cfsd_pkg::OP_CLEAR:  cls.kind = cfsd_pkg::CMD_CLEAR;
            default:             cls_keep = 1'b0;
        endcase
    end

    // Unknown operations are taken and dropped.
    assign s_tready   = (fill_reg != 2'd2);
    assign push       = s_tvalid && s_tready && cls_keep;
    assign head_valid = (fill_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("command queue holds more than two entries");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> fill_reg != 2'd0)
        else $error("command queue popped while empty");

endmodule

@@ hdl/cfsd_scan.sv @@
// ----------------------------------------------------------------------------
// cfsd_scan
// Carries out the queued commands: owns the spec table, appends and clears it,
// and on a decode walks it one entry a cycle, holding while a match waits for
// the arithmetic unit, and passes the extracted raw value of every matching spec on to it.
// ----------------------------------------------------------------------------
module cfsd_scan
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  cfsd_pkg::cmd_t       head,
    output logic                 pop,
    output logic                 job_valid,
    output cfsd_pkg::job_t       job,
    input  logic                 job_ready
);

    cfsd_pkg::scan_state_t state_reg, state_next;

    cfsd_pkg::spec_t tbl_mem [cfsd_pkg::TABLE_DEPTH];
    cfsd_pkg::spec_t rd_reg;
    cfsd_pkg::spec_t wr_spec;

    logic [cfsd_pkg::CNT_W-1:0] count_reg, count_next;
    logic [cfsd_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [cfsd_pkg::IDX_W-1:0] rd_addr;

    logic [15:0] frame_id_reg;
    logic [63:0] frame_data_reg;
    logic [31:0] stamp_reg;

    logic tbl_we;
    logic cnt_clr;
    logic start_scan;
    logic advance;
    logic job_end;
    logic match;
    logic last_entry;

    logic [7:0]  src_byte [8];
    logic [7:0]  raw_byte [8];
    logic [63:0] raw64;
    logic        sign_fill;

    assign match      = (rd_reg.frame_id == frame_id_reg);
    assign last_entry = ((cfsd_pkg::CNT_W'(idx_reg) + 1'b1) == count_reg);

    assign wr_spec.frame_id   = head.frame_id;
    assign wr_spec.start_byte = head.start_byte;
    assign wr_spec.byte_count = head.byte_count;
    assign wr_spec.is_signed  = head.is_signed;
    assign wr_spec.big_endian = head.big_endian;
    assign wr_spec.scale_q16  = head.scale_q16;
    assign wr_spec.offset_q16 = head.offset_q16;

    // Byte gather: output byte p takes payload byte start+p (little endian)
    // or start+count-1-p (big endian), both modulo eight.
    always_comb
    begin
        logic [2:0] sel;
        logic [2:0] top_sel;
        logic [2:0] cnt3;

        cnt3    = rd_reg.byte_count[2:0];
        top_sel = rd_reg.big_endian ? rd_reg.start_byte
                                    : rd_reg.start_byte + cnt3 - 3'd1;
        for (int b = 0; b < 8; b++)
        begin
            src_byte[b] = frame_data_reg[8*b +: 8];
        end
        sign_fill = rd_reg.is_signed && (rd_reg.byte_count != 4'd0)
                    && (rd_reg.byte_count != 4'd8) && src_byte[top_sel][7];
        for (int p = 0; p < 8; p++)
        begin
            sel = rd_reg.big_endian ? (rd_reg.start_byte + cnt3 - 3'd1 - 3'(p))
                                    : (rd_reg.start_byte + 3'(p));
            if (4'(p) < rd_reg.byte_count)
            begin
                raw_byte[p] = src_byte[sel];
            end
            else
            begin
                raw_byte[p] = sign_fill ? 8'hFF : 8'h00;
            end
            raw64[8*p +: 8] = raw_byte[p];
        end
    end

    assign job.is_end     = job_end;
    assign job.spec_index = idx_reg;
    assign job.stamp      = stamp_reg;
    assign job.raw        = {rd_reg.is_signed & raw64[63], raw64};
    assign job.scale_q16  = rd_reg.scale_q16;
    assign job.offset_q16 = rd_reg.offset_q16;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfsd_pkg::SCAN_IDLE:
            begin
                if (head_valid && (head.kind == cfsd_pkg::CMD_DECODE)
                    && (count_reg != '0))
                begin
                    state_next = cfsd_pkg::SCAN_CHECK;
                end
            end
            cfsd_pkg::SCAN_CHECK:
            begin
                if (!(match && !job_ready) && last_entry)
                begin
                    state_next = cfsd_pkg::SCAN_END;
                end
            end
            cfsd_pkg::SCAN_END:
            begin
                if (job_ready)
                begin
                    state_next = cfsd_pkg::SCAN_IDLE;
                end
            end
            default: state_next = cfsd_pkg::SCAN_IDLE;
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        tbl_we     = 1'b0;
        cnt_clr    = 1'b0;
        start_scan = 1'b0;
        advance    = 1'b0;
        job_valid  = 1'b0;
        job_end    = 1'b0;
        rd_addr    = idx_reg;
        unique case (state_reg)
            cfsd_pkg::SCAN_IDLE:
            begin
                pop     = head_valid;
                rd_addr = '0;
                if (head_valid)
                begin
                    unique case (head.kind)
                        cfsd_pkg::CMD_APPEND:
                            tbl_we = (count_reg < cfsd_pkg::CNT_W'(cfsd_pkg::TABLE_DEPTH));
                        cfsd_pkg::CMD_CLEAR:  cnt_clr    = 1'b1;
                        cfsd_pkg::CMD_DECODE: start_scan = (count_reg != '0);
                        default: ;
                    endcase
                end
            end
            cfsd_pkg::SCAN_CHECK:
            begin
                job_valid = match;
                advance   = !(match && !job_ready);
                rd_addr   = advance ? idx_reg + 1'b1 : idx_reg;
            end
            cfsd_pkg::SCAN_END:
            begin
                job_valid = 1'b1;
                job_end   = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cnt_clr)
        begin
            count_next = '0;
        end
        else if (tbl_we)
        begin
            count_next = count_reg + 1'b1;
        end

        idx_next = idx_reg;
        if (start_scan)
        begin
            idx_next = '0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfsd_pkg::SCAN_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[count_reg[cfsd_pkg::IDX_W-1:0]] <= wr_spec;
        end
        rd_reg <= tbl_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (start_scan)
        begin
            frame_id_reg   <= head.frame_id;
            frame_data_reg <= head.frame_data;
            stamp_reg      <= head.stamp;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cfsd_pkg::CNT_W'(cfsd_pkg::TABLE_DEPTH))
        else $error("spec count beyond table depth");

    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cfsd_pkg::SCAN_CHECK)
        |-> (cfsd_pkg::CNT_W'(idx_reg) < count_reg))
        else $error("scan index outside the filled table");

endmodule

@@ hdl/cfsd_arith.sv @@
// ----------------------------------------------------------------------------
// cfsd_arith
// Multiplies a raw value by the scale in two 33 by 32 bit steps, adds the
// offset, saturates to 64 bits and holds one result back so that the final
// result of a frame can be marked when the end of the frame arrives.
// ----------------------------------------------------------------------------
module cfsd_arith
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            job_valid,
    input  cfsd_pkg::job_t                  job,
    output logic                            job_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cfsd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);

    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

    cfsd_pkg::arith_state_t state_reg, state_next;

    cfsd_pkg::job_t      job_reg;
    logic signed [64:0]  plo_reg, plo_next;
    logic signed [64:0]  phi_reg, phi_next;
    logic signed [97:0]  sum_reg, sum_next;
    logic [63:0]         sat_value;
    logic                fits;

    logic                      pend_valid_reg;
    logic [cfsd_pkg::IDX_W-1:0] pend_idx_reg;
    logic [31:0]               pend_stamp_reg;
    logic [63:0]               pend_value_reg;

    logic                      out_valid_reg;
    logic [cfsd_pkg::IDX_W-1:0] out_idx_reg;
    logic [31:0]               out_stamp_reg;
    logic [63:0]               out_value_reg;
    logic                      out_last_reg;

    logic out_free;
    logic ld_job, ld_lo, ld_hi, ld_sum;
    logic ld_pend, clr_pend, move_out, move_last;

    assign out_free = !out_valid_reg || m_tready;

    // Low half of the raw value is unsigned, high half carries the sign.
    assign plo_next = $signed({1'b0, job_reg.raw[31:0]}) * $signed(job_reg.scale_q16);
    assign phi_next = $signed(job_reg.raw[64:32]) * $signed(job_reg.scale_q16);
    assign sum_next = $signed({phi_reg[64], phi_reg, 32'd0})
                    + $signed({{33{plo_reg[64]}}, plo_reg})
                    + $signed({{50{job_reg.offset_q16[47]}}, job_reg.offset_q16});

    assign fits      = (&sum_reg[97:63]) || !(|sum_reg[97:63]);
    assign sat_value = fits ? sum_reg[63:0] : (sum_reg[97] ? SAT_MIN : SAT_MAX);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfsd_pkg::AR_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = job.is_end ? cfsd_pkg::AR_FLUSH : cfsd_pkg::AR_MUL_LO;
                end
            end
            cfsd_pkg::AR_MUL_LO: state_next = cfsd_pkg::AR_MUL_HI;
            cfsd_pkg::AR_MUL_HI: state_next = cfsd_pkg::AR_SUM;
            cfsd_pkg::AR_SUM:    state_next = cfsd_pkg::AR_PLACE;
            cfsd_pkg::AR_PLACE, cfsd_pkg::AR_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = cfsd_pkg::AR_IDLE;
                end
            end
            default: state_next = cfsd_pkg::AR_IDLE;
        endcase
    end

    always_comb
    begin
        job_ready = 1'b0;
        ld_job    = 1'b0;
        ld_lo     = 1'b0;
        ld_hi     = 1'b0;
        ld_sum    = 1'b0;
        ld_pend   = 1'b0;
        clr_pend  = 1'b0;
        move_out  = 1'b0;
        move_last = 1'b0;
        unique case (state_reg)
            cfsd_pkg::AR_IDLE:
            begin
                job_ready = 1'b1;
                ld_job    = job_valid;
            end
            cfsd_pkg::AR_MUL_LO: ld_lo  = 1'b1;
            cfsd_pkg::AR_MUL_HI: ld_hi  = 1'b1;
            cfsd_pkg::AR_SUM:    ld_sum = 1'b1;
            cfsd_pkg::AR_PLACE:
            begin
                // A new result pushes the held one out as not last.
                if (!pend_valid_reg)
                begin
                    ld_pend = 1'b1;
                end
                else if (out_free)
                begin
                    ld_pend  = 1'b1;
                    move_out = 1'b1;
                end
            end
            cfsd_pkg::AR_FLUSH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    move_out  = 1'b1;
                    move_last = 1'b1;
                    clr_pend  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cfsd_pkg::AR_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ld_pend)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (clr_pend)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (move_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_job)
        begin
            job_reg <= job;
        end
        if (ld_lo)
        begin
            plo_reg <= plo_next;
        end
        if (ld_hi)
        begin
            phi_reg <= phi_next;
        end
        if (ld_sum)
        begin
            sum_reg <= sum_next;
        end
        if (move_out)
        begin
            out_idx_reg   <= pend_idx_reg;
            out_stamp_reg <= pend_stamp_reg;
            out_value_reg <= pend_value_reg;
            out_last_reg  <= move_last;
        end
        if (ld_pend)
        begin
            pend_idx_reg   <= job_reg.spec_index;
            pend_stamp_reg <= job_reg.stamp;
            pend_value_reg <= sat_value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_value_reg, out_stamp_reg, out_idx_reg};

    a_move_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        move_out |-> pend_valid_reg)
        else $error("output loaded without a held result");

    a_move_shows: assert property (@(posedge clk) disable iff (!rst_n)
        move_out |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

@@ hdl/can_frame_signal_decoder_top.sv @@
// ----------------------------------------------------------------------------
// can_frame_signal_decoder_top
// Decodes CAN frame payloads into scaled signal values from a table of up to
// 64 signal specs that is filled, and emptied, through the input stream.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid / s_tready  tuser: op; tdata: spec or frame fields
// m_*       out  m_tvalid / m_tready  tdata: spec_index, out_stamp,
//                                     scaled_value; tlast: last
//
// An append or a clear word is carried out by the scanner in its idle state. A
// decode word walks the filled part of the table at one entry a cycle through
// the table's registered read port while no match waits for the arithmetic
// unit; a matching spec holds the walk while the arithmetic unit is busy with
// the previous match, running its two 33 by 32 bit multiply steps, the sum
// and the placement. The front end takes further words into its
// two-entry queue while a decode is under way, and a finished result waits in
// the output register without blocking the arithmetic unit for one more
// result. Reset empties the queue and the table count at once; no clearing
// pass is needed, as only entries below the count are ever used.
//
// The last result of a frame is known only when the walk ends, so one result
// is always held back and leaves with tlast set once the frame is finished.
// ----------------------------------------------------------------------------
module can_frame_signal_decoder_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // From bit 0: frame_id[16], frame_data[64], stamp[32], start_byte[3],
    // byte_count[4], is_signed[1], big_endian[1], scale_q16[32],
    // offset_q16[48], zero padding[7].
    input  logic [cfsd_pkg::S_TDATA_W-1:0]  s_tdata,
    // From bit 0: op[2].
    input  logic [cfsd_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // From bit 0: spec_index[6], out_stamp[32], scaled_value[64],
    // zero padding[2].
    output logic [cfsd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);

    logic           head_valid;
    cfsd_pkg::cmd_t head;
    logic           pop;
    logic           job_valid;
    cfsd_pkg::job_t job;
    logic           job_ready;

    // Front end: takes each word, sorts it by operation and queues it unless the operation is unknown.
    cfsd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // Scanner: owns the spec table and walks it for each decode on a non-empty table.
    cfsd_scan u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .job_valid  (job_valid),
        .job        (job),
        .job_ready  (job_ready)
    );

    // Arithmetic unit and output register.
    cfsd_arith u_arith
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job        (job),
        .job_ready  (job_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CAN frame signal decoder. It fills the spec
// table with append words, empties it with clear words and sends decode
// words. Each accepted word also goes to a model of the table. The model
// predicts the scaled values, and each result word is checked against the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         STALL_LIMIT  = 5000;
    localparam int         LONG_HOLD    = 500;
    localparam int         DRAIN_CYCLES = 400;
    localparam int         WORD_TARGET  = 420;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] frame_id;
        logic [63:0] frame_data;
        logic [31:0] stamp;
        logic [2:0]  start_byte;
        logic [3:0]  byte_count;
        logic        is_signed;
        logic        big_endian;
        logic [31:0] scale_q16;
        logic [47:0] offset_q16;
    } word_t;

    typedef struct {
        logic [15:0] frame_id;
        logic [2:0]  start_byte;
        logic [3:0]  byte_count;
        logic        is_signed;
        logic        big_endian;
        logic [31:0] scale_q16;
        logic [47:0] offset_q16;
    } sig_spec_t;

    typedef struct {
        logic [5:0]  spec_index;
        logic [31:0] stamp;
        logic [63:0] value;
        logic        last;
    } sig_result_t;

    // Holds a copy of the spec table and the values that decoded frames
    // are still owed.
    class signal_scoreboard;
        sig_spec_t   specs[cfsd_pkg::TABLE_DEPTH];
        int unsigned n_specs;
        sig_result_t due_values[$];
        int unsigned mismatches;

        function int unsigned outstanding();
            return due_values.size();
        endfunction

        function int unsigned spec_total();
            return n_specs;
        endfunction

        // Gathers the signal bytes in order and sign-extends short signed raws.
        function logic [63:0] extract_raw(logic [63:0] data, sig_spec_t s);
            logic [63:0] raw;
            int          n;
            int          sh;
            raw = '0;
            n   = s.byte_count;
            for (int i = 0; i < n; i++)
            begin
                sh = s.big_endian ? n - 1 - i : i;
                raw[8*sh +: 8] = data[8*(s.start_byte + i) +: 8];
            end
            if (s.is_signed && n > 0 && n < 8 && raw[8*n-1])
            begin
                for (int b = 8 * n; b < 64; b++)
                    raw[b] = 1'b1;
            end
            return raw;
        endfunction

        // Exact raw * scale + offset, then clipped to the signed 64-bit range.
        function logic [63:0] apply_scale(logic [63:0] raw, sig_spec_t s);
            logic signed [129:0] a;
            logic signed [129:0] b;
            logic signed [129:0] c;
            logic signed [129:0] p;
            a = s.is_signed ? {{66{raw[63]}}, raw} : {66'b0, raw};
            b = {{98{s.scale_q16[31]}}, s.scale_q16};
            c = {{82{s.offset_q16[47]}}, s.offset_q16};
            p = a * b + c;
            if (p[129:63] == '0 || p[129:63] == '1)
                return p[63:0];
            return p[129] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        endfunction

        // Returns 0 when the block ignores the word (an unused op, an append to a full table), else 1.
        function bit note_word(word_t w);
            sig_spec_t   s;
            sig_result_t r;
            int unsigned first;
            int unsigned n;
            case (w.op)
                cfsd_pkg::OP_APPEND:
                begin
                    if (n_specs >= cfsd_pkg::TABLE_DEPTH)
                        return 1'b0;
                    n = w.byte_count;
                    if (n > 8 - w.start_byte)
                        n = 8 - w.start_byte;
                    s.frame_id   = w.frame_id;
                    s.start_byte = w.start_byte;
                    s.byte_count = 4'(n);
                    s.is_signed  = w.is_signed;
                    s.big_endian = w.big_endian;
                    s.scale_q16  = w.scale_q16;
                    s.offset_q16 = w.offset_q16;
                    specs[n_specs] = s;
                    n_specs++;
                    return 1'b1;
                end
                cfsd_pkg::OP_CLEAR:
                begin
                    n_specs = 0;
                    return 1'b1;
                end
                cfsd_pkg::OP_DECODE:
                begin
                    first = due_values.size();
                    for (int i = 0; i < n_specs; i++)
                    begin
                        if (specs[i].frame_id == w.frame_id)
                        begin
                            r.spec_index = 6'(i);
                            r.stamp      = w.stamp;
                            r.value      = apply_scale(extract_raw(w.frame_data, specs[i]),
                                                       specs[i]);
                            r.last       = 1'b0;
                            due_values.insert(due_values.size(), r);
                        end
                    end
                    if (due_values.size() > first)
                        due_values[due_values.size()-1].last = 1'b1;
                    return 1'b1;
                end
                default:
                    return 1'b0;
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [5:0] idx, logic [31:0] stamp, logic [63:0] value,
                          logic last);
            sig_result_t want;
            if (due_values.size() == 0)
            begin
                report($sformatf("unexpected result word: index %0d stamp %h value %h last %b",
                                 idx, stamp, value, last));
                return;
            end
            want = due_values.pop_front();
            if (idx !== want.spec_index)
                report($sformatf("spec_index: got %0d, expected %0d", idx, want.spec_index));
            if (stamp !== want.stamp)
                report($sformatf("out_stamp: got %h, expected %h", stamp, want.stamp));
            if (value !== want.value)
                report($sformatf("scaled_value (index %0d): got %h, expected %h",
                                 want.spec_index, value, want.value));
            if (last !== want.last)
                report($sformatf("tlast (index %0d): got %b, expected %b",
                                 want.spec_index, last, want.last));
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [cfsd_pkg::S_TDATA_W-1:0] s_tdata;
    logic [cfsd_pkg::S_TUSER_W-1:0] s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [cfsd_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tlast;

    signal_scoreboard sb = new();
    bit               hold_request = 1'b0;
    bit               source_bursty = 1'b0;
    int unsigned      effective_words = 0;
    int unsigned      idle_cycles = 0;

    can_frame_signal_decoder_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic word_t make_append(logic [15:0] id, logic [2:0] start, logic [3:0] cnt,
                                          logic sgn, logic big, logic [31:0] scale,
                                          logic [47:0] offset);
        word_t w;
        w.op         = cfsd_pkg::OP_APPEND;
        w.frame_id   = id;
        w.frame_data = {$urandom, $urandom};
        w.stamp      = $urandom;
        w.start_byte = start;
        w.byte_count = cnt;
        w.is_signed  = sgn;
        w.big_endian = big;
        w.scale_q16  = scale;
        w.offset_q16 = offset;
        return w;
    endfunction

    // The spec fields of a decode word are don't-care, so they carry noise.
    function automatic word_t make_decode(logic [15:0] id, logic [63:0] data,
                                          logic [31:0] stamp);
        word_t w;
        w.op         = cfsd_pkg::OP_DECODE;
        w.frame_id   = id;
        w.frame_data = data;
        w.stamp      = stamp;
        w.start_byte = 3'($urandom);
        w.byte_count = 4'($urandom);
        w.is_signed  = 1'($urandom);
        w.big_endian = 1'($urandom);
        w.scale_q16  = $urandom;
        w.offset_q16 = {16'($urandom), $urandom};
        return w;
    endfunction

    function automatic word_t make_noise();
        word_t w;
        w    = make_decode(16'($urandom), {$urandom, $urandom}, $urandom);
        w.op = OP_UNUSED;
        return w;
    endfunction

    // Offers one word after a random gap, or at once when the source is bursty, and waits for it to be taken.
    // Starts and ends just after a falling edge.
    task automatic send_word(input word_t w);
        int unsigned gap;
        gap = source_bursty ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.op;
        s_tdata  <= {7'b0, w.offset_q16, w.scale_q16, w.big_endian, w.is_signed,
                     w.byte_count, w.start_byte, w.stamp, w.frame_data, w.frame_id};
        do
            @(posedge clk);
        while (!s_tready);
        if (sb.note_word(w))
            effective_words++;
        @(negedge clk);
    endtask

    // Result side: a random stall before each word outside bursty spells, a long hold instead when asked.
    initial
    begin : result_sink
        int unsigned stall;
        bit          sink_bursty;
        sink_bursty = 1'b0;
        m_tready    = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                if ($urandom_range(0, 39) == 0)
                    sink_bursty = !sink_bursty;
                stall = sink_bursty ? 0 : $urandom_range(0, 15);
                if (stall != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_result(m_tdata[5:0], m_tdata[37:6], m_tdata[101:38], m_tlast);
            @(negedge clk);
        end
    end

    // Ends the run when neither side has moved a word for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [15:0] pool[4];
        int unsigned pool_n;
        int unsigned n_app;
        int unsigned n_dec;
        int unsigned phase;
        bit          big_phase;
        logic        sgn;
        logic [31:0] scale;
        logic [47:0] offset;
        logic [15:0] id;
        logic [63:0] data;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: empty table, extreme specs and payloads, clamping,
        // zero-length signals, an unmatched id, clear and the unused op.
        send_word(make_decode(16'h0000, 64'h0123_4567_89AB_CDEF, 32'h0));
        send_word(make_noise());
        send_word(make_append(16'hFFFF, 3'd0, 4'd8, 1'b1, 1'b0, 32'h7FFF_FFFF,
                              48'h7FFF_FFFF_FFFF));
        send_word(make_append(16'hFFFF, 3'd7, 4'd8, 1'b1, 1'b1, 32'h8000_0000,
                              48'h8000_0000_0000));
        send_word(make_append(16'h0000, 3'd0, 4'd0, 1'b0, 1'b0, 32'h0001_0000,
                              48'h0000_0000_0123));
        send_word(make_append(16'h0000, 3'd2, 4'd3, 1'b0, 1'b1, 32'hFFFF_FFFF, 48'h0));
        send_word(make_append(16'h0000, 3'd5, 4'd4, 1'b1, 1'b0, 32'h0001_0000,
                              48'hFFFF_FFFF_FFFF));
        send_word(make_append(16'h1234, 3'd0, 4'd8, 1'b0, 1'b1, 32'h8000_0000, 48'h0));
        send_word(make_append(16'h1234, 3'd1, 4'd6, 1'b1, 1'b1, 32'h0000_0000, 48'h1));
        send_word(make_decode(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        send_word(make_decode(16'hFFFF, 64'h8000_0000_0000_0080, 32'h5555_AAAA));
        send_word(make_decode(16'hFFFF, 64'h7F00_0000_0000_007F, 32'h0000_0001));
        send_word(make_decode(16'h0000, 64'h0, 32'h0));
        send_word(make_decode(16'h0000, 64'hFEDC_BA98_7654_3210, 32'hAAAA_5555));
        send_word(make_decode(16'h1234, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000));
        send_word(make_decode(16'h1234, 64'h8000_0000_0000_0000, 32'h7FFF_FFFF));
        send_word(make_decode(16'h4321, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678));
        send_word(make_decode(16'h0000, 64'h0, 32'h0));
        send_word(make_append(16'hABCD, 3'd3, 4'd2, 1'b1, 1'b1, 32'h0001_0000,
                              48'hFFFF_FFFF_FFFF));
        send_word(make_decode(16'hABCD, 64'h0000_0000_8001_0000, 32'h0000_FFFF));
        begin
            word_t w;
            w    = make_decode(16'h0, 64'h0, 32'h0);
            w.op = cfsd_pkg::OP_CLEAR;
            send_word(w);
            send_word(make_decode(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0));
        end
        send_word(make_noise());

        // Random part: each phase may empty the table, appends specs for a
        // small pool of ids and decodes frames that mostly hit that pool.
        phase = 0;
        while (effective_words < WORD_TARGET)
        begin
            phase++;
            big_phase     = (phase == 2) || (phase % 9 == 5);
            source_bursty = ($urandom_range(0, 3) == 0);
            if (big_phase || sb.spec_total() > 40 || $urandom_range(0, 2) == 0)
            begin
                word_t w;
                w    = make_noise();
                w.op = cfsd_pkg::OP_CLEAR;
                send_word(w);
            end
            pool_n = big_phase ? $urandom_range(1, 2) : $urandom_range(1, 4);
            for (int k = 0; k < 4; k++)
                pool[k] = 16'($urandom);
            n_app = big_phase ? 70 : $urandom_range(1, 10);
            n_dec = big_phase ? $urandom_range(2, 4) : $urandom_range(2, 8);
            // Once, the result side holds off while decodes keep coming, so
            // that the block backs up and stops taking words.
            if (phase == 4)
            begin
                hold_request  = 1'b1;
                source_bursty = 1'b1;
                n_dec         = 12;
            end
            while (n_app + n_dec > 0)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_word(make_noise());
                if (n_app > 0 && (big_phase || n_dec == 0 ||
                                  $urandom_range(0, n_app + n_dec - 1) < n_app))
                begin
                    sgn = 1'($urandom);
                    case ($urandom_range(0, 3))
                        0: scale = $urandom;
                        1: scale = {{12{sgn}}, 20'($urandom)};
                        2:
                        begin
                            case ($urandom_range(0, 3))
                                0: scale = 32'h7FFF_FFFF;
                                1: scale = 32'h8000_0000;
                                2: scale = 32'h0000_0000;
                                default: scale = 32'hFFFF_FFFF;
                            endcase
                        end
                        default: scale = {{8{sgn}}, 8'($urandom), 16'h0};
                    endcase
                    case ($urandom_range(0, 3))
                        0: offset = {16'($urandom), $urandom};
                        1: offset = 1'($urandom) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
                        default: offset = {{32{sgn}}, 16'($urandom)};
                    endcase
                    send_word(make_append(pool[$urandom_range(0, pool_n - 1)],
                                          3'($urandom), 4'($urandom_range(0, 8)),
                                          1'($urandom), 1'($urandom), scale, offset));
                    n_app--;
                end
                else
                begin
                    id = ($urandom_range(0, 19) < 17) ? pool[$urandom_range(0, pool_n - 1)]
                                                      : 16'($urandom);
                    case ($urandom_range(0, 7))
                        0: data = 64'hFFFF_FFFF_FFFF_FFFF;
                        1: data = 64'h0;
                        2: data = 64'h8080_8080_8080_8080;
                        default: data = {$urandom, $urandom};
                    endcase
                    send_word(make_decode(id, data, $urandom));
                    n_dec--;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ can_frame_signal_decoder_top.f @@
hdl/cfsd_pkg.sv
hdl/cfsd_front.sv
hdl/cfsd_scan.sv
hdl/cfsd_arith.sv
hdl/can_frame_signal_decoder_top.sv
sim/tb.sv
